// ----- src/srq_pkg.sv -----
// ----------------------------------------------------------------------------
// srq_pkg: shared types and codes of the sorted ready queue
// Entry and travelling-item formats, request and status codes.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int ID_W   = 16;
  localparam int TIME_W = 16;
  localparam int CNT_W  = 5;

  localparam logic [1:0] REQ_APPEND  = 2'd0;
  localparam logic [1:0] REQ_ORDERED = 2'd1;
  localparam logic [1:0] REQ_POP     = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] est;
  } entry_t;

  // item moving down the cell row; once placed, it is a displaced entry
  // that drops into the first free cell
  typedef struct packed {
    logic   vld;
    logic   placed;
    logic   ordered;
    entry_t ent;
  } carry_t;

endpackage

// ----- src/srq_cell.sv -----
// ----------------------------------------------------------------------------
// srq_cell: one slot of the queue
// Holds one entry, shifts toward the head on pop, and swaps with the item
// passing down the row on a push.
// ----------------------------------------------------------------------------
module srq_cell #(
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  srq_pkg::entry_t right_entry,
  input  logic [IW-1:0]   wave_base,
  input  srq_pkg::carry_t carry_in,
  output srq_pkg::entry_t entry,
  output srq_pkg::carry_t carry_out
);

  logic            tail;
  logic            take;
  srq_pkg::carry_t carry_next;

  // first free slot of the queue for the push in flight
  assign tail = (wave_base == IW'(INDEX));

  assign take = carry_in.vld &&
                (tail || carry_in.placed ||
                 (carry_in.ordered && (entry.est > carry_in.ent.est)));

  always_comb begin
    carry_next     = carry_in;
    carry_next.vld = carry_in.vld && !tail;
    if (take) begin
      carry_next.placed = 1'b1;
      carry_next.ent    = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= right_entry;
    end else if (take) begin
      entry <= carry_in.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
    end
  end

endmodule

// ----- src/sorted_ready_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_ready_queue: bounded shortest-job-first queue for ordered pushes
// Row of slot cells; pushes travel down the row one cell per cycle.
// ----------------------------------------------------------------------------
// The result is registered in the cycle after the request is taken.
// Pops and refused requests do not hold the cell row; a push holds it,
//   stalling new requests, while the item moves down to the tail.
// Reset: the queue is empty; slot contents are undefined until written.
// ----------------------------------------------------------------------------
module sorted_ready_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] proc_id,
  input  logic [15:0] est_time,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [15:0] popped_id,
  output logic [15:0] popped_time,
  output logic [4:0]  count_after
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   wave_left;
  logic [IW-1:0]   wave_base;
  srq_pkg::carry_t inject;

  srq_pkg::entry_t entries [DEPTH];
  srq_pkg::carry_t carries [DEPTH];

  logic accept;
  logic is_push;
  logic is_pop;
  logic full;
  logic empty;
  logic push_ok;
  logic pop_ok;
  logic [1:0] status_next;
  logic [CW+4:0] count_ext;

  assign req_stall = (wave_left != '0) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  assign is_push = (req_type == srq_pkg::REQ_APPEND) || (req_type == srq_pkg::REQ_ORDERED);
  assign is_pop  = (req_type == srq_pkg::REQ_POP);
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = accept && is_push && !full;
  assign pop_ok  = accept && is_pop && !empty;

  always_comb begin
    count_next  = count;
    status_next = srq_pkg::ST_DONE;
    if (is_push) begin
      if (full) begin
        status_next = srq_pkg::ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else if (is_pop) begin
      if (empty) begin
        status_next = srq_pkg::ST_EMPTY;
      end else begin
        count_next = count - CW'(1);
      end
    end
  end

  assign count_ext = {5'd0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      wave_left  <= '0;
      inject.vld <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      inject.vld <= push_ok;
      if (push_ok) begin
        inject.placed  <= 1'b0;
        inject.ordered <= (req_type == srq_pkg::REQ_ORDERED);
        inject.ent.id  <= proc_id;
        inject.ent.est <= est_time;
      end
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (push_ok) begin
        wave_left <= count + CW'(1);
      end else if (wave_left != '0) begin
        wave_left <= wave_left - CW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push_ok) begin
      wave_base <= count[IW-1:0];
    end
    if (accept) begin
      status      <= status_next;
      count_after <= count_ext[4:0];
      if (pop_ok) begin
        popped_id   <= entries[0].id;
        popped_time <= entries[0].est;
      end else begin
        popped_id   <= '0;
        popped_time <= '0;
      end
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    srq_cell #(
      .IW    (IW),
      .INDEX (k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (pop_ok),
      .right_entry ((k == DEPTH - 1) ? entries[k] : entries[(k + 1) % DEPTH]),
      .wave_base   (wave_base),
      .carry_in    ((k == 0) ? inject : carries[(k + DEPTH - 1) % DEPTH]),
      .entry       (entries[k]),
      .carry_out   (carries[k])
    );
  end

endmodule
